/* rtl/core/mks_pkg.sv */
package mks_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned UnitTickW = 16;
  localparam int unsigned UnitW     = 7;
  localparam int unsigned DurW      = 23;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CodeCount = 38;
  localparam int unsigned CodeIdxW  = 6;
  localparam int unsigned CodeLenW  = 4;
  localparam int unsigned StepW     = 3;
  localparam int unsigned MaxElementsDef = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegUnitTicks  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDotUnits   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDashUnits  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGapUnits   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpaceUnits = 3'd4;

  localparam logic [UnitTickW-1:0] UnitTicksRst  = 16'd9999;
  localparam logic [UnitW-1:0]     DotUnitsRst   = 7'd1;
  localparam logic [UnitW-1:0]     DashUnitsRst  = 7'd3;
  localparam logic [UnitW-1:0]     GapUnitsRst   = 7'd3;
  localparam logic [UnitW-1:0]     SpaceUnitsRst = 7'd4;

  // program step addresses
  localparam logic [StepW-1:0] StepFetch = 3'd0;
  localparam logic [StepW-1:0] StepMark  = 3'd1;
  localparam logic [StepW-1:0] StepGap   = 3'd2;
  localparam logic [StepW-1:0] StepWord  = 3'd3;
  localparam logic [StepW-1:0] StepBad   = 3'd4;

  typedef enum logic [1:0] {
    KindSym   = 2'd0,
    KindSpace = 2'd1,
    KindBad   = 2'd2
  } char_kind_e;

  typedef enum logic [1:0] {
    UselZero  = 2'd0,
    UselSpace = 2'd1,
    UselElem  = 2'd2,  // dash or dot by current element
    UselGap   = 2'd3   // gap on final element, else dot
  } unit_sel_e;

  typedef enum logic [1:0] {
    LselNone   = 2'd0,
    LselAlways = 2'd1,
    LselFinal  = 2'd2
  } last_sel_e;

  typedef enum logic [1:0] {
    JcDispatch = 2'd0,
    JcNext     = 2'd1,
    JcLoop     = 2'd2,  // final element: back to fetch, else to target
    JcJump     = 2'd3
  } jump_cond_e;

  typedef struct packed {
    logic              emit;
    logic              key_on;
    unit_sel_e         usel;
    last_sel_e         lsel;
    logic              bad;
    jump_cond_e        jc;
    logic [StepW-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    char_kind_e           kind;
    logic [CodeIdxW-1:0]  idx;
  } char_class_t;

  function automatic ctrl_word_t program_rom(logic [StepW-1:0] step);
    ctrl_word_t cw;
    cw = '{emit: 1'b0, key_on: 1'b0, usel: UselZero, lsel: LselNone, bad: 1'b0,
           jc: JcDispatch, target: StepFetch};
    case (step)
      StepMark: begin
        cw = '{emit: 1'b1, key_on: 1'b1, usel: UselElem, lsel: LselNone, bad: 1'b0,
               jc: JcNext, target: StepGap};
      end
      StepGap: begin
        cw = '{emit: 1'b1, key_on: 1'b0, usel: UselGap, lsel: LselFinal, bad: 1'b0,
               jc: JcLoop, target: StepMark};
      end
      StepWord: begin
        cw = '{emit: 1'b1, key_on: 1'b0, usel: UselSpace, lsel: LselAlways, bad: 1'b0,
               jc: JcJump, target: StepFetch};
      end
      StepBad: begin
        cw = '{emit: 1'b1, key_on: 1'b0, usel: UselZero, lsel: LselAlways, bad: 1'b1,
               jc: JcJump, target: StepFetch};
      end
      default: ;
    endcase
    return cw;
  endfunction

  function automatic char_class_t classify(logic [CharW-1:0] ch);
    char_class_t  cc;
    logic [CharW-1:0] up;
    up = ch;
    cc = '{kind: KindBad, idx: '0};
    if (ch inside {[8'd97:8'd122]}) up = ch - 8'd32;
    if (ch == 8'd32) begin
      cc.kind = KindSpace;
    end else if (up inside {[8'd48:8'd57]}) begin
      cc.kind = KindSym;
      cc.idx  = CodeIdxW'(up - 8'd48);
    end else if (up inside {[8'd65:8'd92]}) begin
      cc.kind = KindSym;
      cc.idx  = CodeIdxW'(up - 8'd55);
    end
    return cc;
  endfunction

  // dash = 1, first element in bit 7
  function automatic logic [7:0] code_bits(logic [CodeIdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:  b = 8'hF8;  6'd1:  b = 8'h78;  6'd2:  b = 8'h38;  6'd3:  b = 8'h18;
      6'd4:  b = 8'h08;  6'd5:  b = 8'h00;  6'd6:  b = 8'h80;  6'd7:  b = 8'hC0;
      6'd8:  b = 8'hE0;  6'd9:  b = 8'hF0;  6'd10: b = 8'h40;  6'd11: b = 8'h80;
      6'd12: b = 8'hA0;  6'd13: b = 8'h80;  6'd14: b = 8'h00;  6'd15: b = 8'h20;
      6'd16: b = 8'hC0;  6'd17: b = 8'h00;  6'd18: b = 8'h00;  6'd19: b = 8'h70;
      6'd20: b = 8'hA0;  6'd21: b = 8'h40;  6'd22: b = 8'hC0;  6'd23: b = 8'h80;
      6'd24: b = 8'hE0;  6'd25: b = 8'h60;  6'd26: b = 8'hD0;  6'd27: b = 8'h40;
      6'd28: b = 8'h00;  6'd29: b = 8'h80;  6'd30: b = 8'h20;  6'd31: b = 8'h10;
      6'd32: b = 8'h60;  6'd33: b = 8'h90;  6'd34: b = 8'hB0;  6'd35: b = 8'hC0;
      6'd36: b = 8'hAD;  6'd37: b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [CodeLenW-1:0] code_len(logic [CodeIdxW-1:0] idx);
    logic [CodeLenW-1:0] n;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9: n = 4'd5;
      6'd14, 6'd29: n = 4'd1;
      6'd10, 6'd18, 6'd22, 6'd23: n = 4'd2;
      6'd13, 6'd16, 6'd20, 6'd24, 6'd27, 6'd28, 6'd30, 6'd32: n = 4'd3;
      6'd36: n = 4'd8;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/morse_keying_sequencer.sv */
// Channel  | Direction | Handshake               | Payload
// input    | in        | in_valid_i / in_ready_o | character_i, message_last_i
// result   | out       | out_valid_o / out_ready_i | key_on_o, duration_ticks_o,
//          |           |                         | element_last_o, message_end_o,
//          |           |                         | bad_character_o
// config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// A character is taken on the fetch step, then its intervals follow: 2 * elements
// intervals for a symbol (up to 16), one for a space or unknown character.
// The current program step issues one interval per cycle while the result is not stalled.
// A stalled result holds the sequencer on its current step; input is taken
// only on the fetch step. Reset (rst_ni low) returns to fetch and loads the
// default timing registers.
module morse_keying_sequencer #(
  parameter int unsigned MAX_ELEMENTS = mks_pkg::MaxElementsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mks_pkg::CharW-1:0]     character_i,
  input  logic                          message_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          key_on_o,
  output logic [mks_pkg::DurW-1:0]      duration_ticks_o,
  output logic                          element_last_o,
  output logic                          message_end_o,
  output logic                          bad_character_o,
  input  logic                          cfg_we_i,
  input  logic [mks_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mks_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned RemW = $clog2(MAX_ELEMENTS + 1);

  logic [mks_pkg::UnitTickW-1:0] unit_ticks_q;
  logic [mks_pkg::UnitW-1:0]     dot_units_q, dash_units_q, gap_units_q, space_units_q;

  logic [mks_pkg::StepW-1:0] step_q, step_d;
  logic [7:0]                bits_q, bits_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic                      msg_last_q, msg_last_d;

  logic                      out_valid_q, out_valid_d;
  logic                      key_on_q, elem_last_q, msg_end_q, bad_q;
  logic [mks_pkg::DurW-1:0]  dur_q;

  mks_pkg::ctrl_word_t       cw;
  mks_pkg::char_class_t      cc;
  logic [mks_pkg::CodeLenW-1:0] len_raw;
  logic [RemW-1:0]           len_clip;
  logic                      in_fire, emit_go, final_elem, last_now;
  logic [mks_pkg::UnitW-1:0] units;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= mks_pkg::UnitTicksRst;
      dot_units_q   <= mks_pkg::DotUnitsRst;
      dash_units_q  <= mks_pkg::DashUnitsRst;
      gap_units_q   <= mks_pkg::GapUnitsRst;
      space_units_q <= mks_pkg::SpaceUnitsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mks_pkg::RegUnitTicks:  unit_ticks_q  <= cfg_data_i;
        mks_pkg::RegDotUnits:   dot_units_q   <= cfg_data_i[mks_pkg::UnitW-1:0];
        mks_pkg::RegDashUnits:  dash_units_q  <= cfg_data_i[mks_pkg::UnitW-1:0];
        mks_pkg::RegGapUnits:   gap_units_q   <= cfg_data_i[mks_pkg::UnitW-1:0];
        mks_pkg::RegSpaceUnits: space_units_q <= cfg_data_i[mks_pkg::UnitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cw         = mks_pkg::program_rom(step_q);
    cc         = mks_pkg::classify(character_i);
    len_raw    = mks_pkg::code_len(cc.idx);
    len_clip   = (len_raw > mks_pkg::CodeLenW'(MAX_ELEMENTS)) ? RemW'(MAX_ELEMENTS)
                                                             : RemW'(len_raw);
    in_ready_o = (cw.jc == mks_pkg::JcDispatch);
    in_fire    = in_valid_i && in_ready_o;
    emit_go    = cw.emit && (!out_valid_q || out_ready_i);
    final_elem = (rem_q == RemW'(1));

    case (cw.usel)
      mks_pkg::UselSpace: units = space_units_q;
      mks_pkg::UselElem:  units = bits_q[7] ? dash_units_q : dot_units_q;
      mks_pkg::UselGap:   units = final_elem ? gap_units_q : dot_units_q;
      default:            units = '0;
    endcase

    case (cw.lsel)
      mks_pkg::LselAlways: last_now = 1'b1;
      mks_pkg::LselFinal:  last_now = final_elem;
      default:             last_now = 1'b0;
    endcase

    step_d     = step_q;
    bits_d     = bits_q;
    rem_d      = rem_q;
    msg_last_d = msg_last_q;
    case (cw.jc)
      mks_pkg::JcDispatch: begin
        if (in_fire) begin
          msg_last_d = message_last_i;
          bits_d     = mks_pkg::code_bits(cc.idx);
          rem_d      = len_clip;
          case (cc.kind)
            mks_pkg::KindSym:   step_d = mks_pkg::StepMark;
            mks_pkg::KindSpace: step_d = mks_pkg::StepWord;
            default:            step_d = mks_pkg::StepBad;
          endcase
        end
      end
      mks_pkg::JcNext: begin
        if (emit_go) step_d = step_q + mks_pkg::StepW'(1);
      end
      mks_pkg::JcLoop: begin
        if (emit_go) begin
          step_d = final_elem ? mks_pkg::StepFetch : cw.target;
          bits_d = {bits_q[6:0], 1'b0};
          rem_d  = rem_q - RemW'(1);
        end
      end
      default: begin
        if (emit_go) step_d = cw.target;
      end
    endcase

    out_valid_d = out_valid_q;
    if (emit_go) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= mks_pkg::StepFetch;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q     <= bits_d;
    rem_q      <= rem_d;
    msg_last_q <= msg_last_d;
    if (emit_go) begin
      key_on_q    <= cw.key_on;
      dur_q       <= mks_pkg::DurW'(unit_ticks_q * units);
      elem_last_q <= last_now;
      msg_end_q   <= last_now && msg_last_q;
      bad_q       <= cw.bad;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_on_o         = key_on_q;
  assign duration_ticks_o = dur_q;
  assign element_last_o   = elem_last_q;
  assign message_end_o    = msg_end_q;
  assign bad_character_o  = bad_q;

`ifndef SYNTH
  a_bad_is_empty_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_character_o |-> !key_on_o && duration_ticks_o == '0 && element_last_o)
    else $error("unknown character result is not a zero-length final off interval");

  a_mark_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_on_o |-> !element_last_o && !message_end_o)
    else $error("key-on interval marked as last");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> element_last_o)
    else $error("message end outside a character's last interval");

  a_elements_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == mks_pkg::StepMark || step_q == mks_pkg::StepGap |-> rem_q != '0)
    else $error("symbol step with no elements left");
`endif

endmodule
